// ----- sv/srpg_pkg.sv -----
package srpg_pkg;

    // Fixed field widths
    localparam int RQ_BITS    = 8;
    localparam int MAP_BITS   = 11;
    localparam int APB_DW     = 32;
    localparam int PADDR_BITS = 3;

    localparam logic [MAP_BITS-1:0] MAP_RESET = 11'd1024;

    // Register index, taken from paddr[2]
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    // Edge of the current ring, in walk order
    typedef enum logic [1:0] {
        EDGE_TOP,
        EDGE_RIGHT,
        EDGE_BOTTOM,
        EDGE_LEFT
    } t_edge;

    // Jump conditions of the microprogram
    typedef enum logic [1:0] {
        COND_NO_XFER,
        COND_SPENT,
        COND_MISS,
        COND_OUT_BUSY
    } t_cond;

    localparam int UPC_BITS = 2;
    typedef logic [UPC_BITS-1:0] t_upc;

    localparam t_upc STEP_WAIT  = 2'd0;
    localparam t_upc STEP_CHECK = 2'd1;
    localparam t_upc STEP_TEST  = 2'd2;
    localparam t_upc STEP_EMIT  = 2'd3;

    // Datapath controls of one microinstruction
    typedef struct packed {
        logic take_input;
        logic visit;
        logic test;
        logic emit;
    } t_ctrl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic xfer;
        logic spent;
        logic miss;
        logic out_busy;
    } t_status;

    typedef struct packed {
        t_cond cond;
        t_upc  target;
        t_ctrl ctrl;
    } t_uword;

    // Jump to target when cond holds, else fall through; EMIT wraps to WAIT.
    localparam t_uword UCODE [0:(2**UPC_BITS)-1] = '{
        '{cond: COND_NO_XFER, target: STEP_WAIT,
          ctrl: '{take_input: 1'b1, visit: 1'b0, test: 1'b0, emit: 1'b0}},
        '{cond: COND_SPENT, target: STEP_EMIT,
          ctrl: '{take_input: 1'b0, visit: 1'b1, test: 1'b0, emit: 1'b0}},
        '{cond: COND_MISS, target: STEP_CHECK,
          ctrl: '{take_input: 1'b0, visit: 1'b0, test: 1'b1, emit: 1'b0}},
        '{cond: COND_OUT_BUSY, target: STEP_EMIT,
          ctrl: '{take_input: 1'b0, visit: 1'b0, test: 1'b0, emit: 1'b1}}
    };

endpackage

// ----- sv/srpg_seq.sv -----
module srpg_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srpg_pkg::t_status i_status,
    output srpg_pkg::t_ctrl   o_ctrl
);

    srpg_pkg::t_upc   r_upc;
    srpg_pkg::t_upc   n_upc;
    srpg_pkg::t_uword w_word;
    logic             w_jump;

    assign w_word = srpg_pkg::UCODE[r_upc];
    assign o_ctrl = w_word.ctrl;

    always_comb begin
        unique case (w_word.cond)
            srpg_pkg::COND_NO_XFER:  w_jump = !i_status.xfer;
            srpg_pkg::COND_SPENT:    w_jump = i_status.spent;
            srpg_pkg::COND_MISS:     w_jump = i_status.miss;
            srpg_pkg::COND_OUT_BUSY: w_jump = i_status.out_busy;
        endcase
    end

    always_comb begin
        if (w_jump) begin
            n_upc = w_word.target;
        end else begin
            n_upc = r_upc + srpg_pkg::t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= srpg_pkg::STEP_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ----- sv/srpg_dp.sv -----
module srpg_dp #(
    parameter int COORD_BITS       = 10,
    parameter int RADIUS_FRAC_BITS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srpg_pkg::t_ctrl               i_ctrl,
    output srpg_pkg::t_status             o_status,
    input  logic                          i_s_tvalid,
    input  logic                          i_kind,
    input  logic [COORD_BITS-1:0]         i_start_x,
    input  logic [COORD_BITS-1:0]         i_start_y,
    input  logic [srpg_pkg::RQ_BITS-1:0]  i_radius_q,
    input  logic [srpg_pkg::MAP_BITS-1:0] i_map_width,
    input  logic [srpg_pkg::MAP_BITS-1:0] i_map_height,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [COORD_BITS-1:0]         o_point_x,
    output logic [COORD_BITS-1:0]         o_point_y,
    output logic                          o_found
);

    localparam int RQ2_BITS  = srpg_pkg::RQ_BITS + 1;
    localparam int N_BITS    =
        $clog2(((((2 ** srpg_pkg::RQ_BITS) - 1) * 2) >> RADIUS_FRAC_BITS) + 2);
    localparam int D_BITS    = N_BITS + 1;
    localparam int RING_BITS = N_BITS + 1;
    localparam int BUD_BITS  = 2 * N_BITS;
    localparam int AW        =
        ((COORD_BITS > srpg_pkg::MAP_BITS) ? COORD_BITS : srpg_pkg::MAP_BITS) + 2;
    localparam int SUM_W     = 2 * D_BITS + 1 + 2 * RADIUS_FRAC_BITS;
    localparam int RSQ_BITS  = 2 * srpg_pkg::RQ_BITS;

    // Search state
    logic [COORD_BITS-1:0]  r_centre_x;
    logic [COORD_BITS-1:0]  r_centre_y;
    logic signed [D_BITS-1:0] r_dx, n_dx;
    logic signed [D_BITS-1:0] r_dy, n_dy;
    logic [RING_BITS-1:0]   r_ring, n_ring;
    srpg_pkg::t_edge        r_edge, n_edge;
    logic [RING_BITS-1:0]   r_step, n_step;
    logic [BUD_BITS-1:0]    r_visited;
    logic [BUD_BITS-1:0]    r_budget;
    logic [RSQ_BITS-1:0]    r_radius_sq;

    // Candidate under test
    logic [COORD_BITS-1:0]  r_cand_x;
    logic [COORD_BITS-1:0]  r_cand_y;
    logic                   r_on_map;
    logic [2*D_BITS-1:0]    r_sq_x;
    logic [2*D_BITS-1:0]    r_sq_y;
    logic                   r_hit;

    // Output register
    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_out_x;
    logic [COORD_BITS-1:0]  r_out_y;
    logic                   r_out_found;

    logic                   w_xfer;
    logic                   w_start;
    logic                   w_spent;
    logic                   w_visit;
    logic                   w_keep;
    logic                   w_out_busy;
    logic                   w_emit;
    logic [RQ2_BITS-1:0]    w_rq2;
    logic [N_BITS-1:0]      w_n;
    logic signed [AW-1:0]   w_cand_x;
    logic signed [AW-1:0]   w_cand_y;
    logic [AW-2:0]          w_ux;
    logic [AW-2:0]          w_uy;
    logic                   w_on_map;
    logic [SUM_W-1:0]       w_dist;
    logic [SUM_W-1:0]       w_scaled;
    logic [RING_BITS-1:0]   w_step_inc;

    assign w_xfer     = i_s_tvalid && i_ctrl.take_input;
    assign w_start    = w_xfer && !i_kind;
    assign w_spent    = r_visited >= r_budget;
    assign w_visit    = i_ctrl.visit && !w_spent;
    assign w_out_busy = r_out_valid && !i_m_tready;
    assign w_emit     = i_ctrl.emit && !w_out_busy;

    // Side of the spiral box: floor(2*r) + 1
    assign w_rq2 = {i_radius_q, 1'b0} >> RADIUS_FRAC_BITS;
    assign w_n   = N_BITS'(w_rq2) + N_BITS'(1);

    assign w_cand_x = $signed({{(AW - COORD_BITS){1'b0}}, r_centre_x}) + AW'(r_dx);
    assign w_cand_y = $signed({{(AW - COORD_BITS){1'b0}}, r_centre_y}) + AW'(r_dy);
    assign w_ux     = w_cand_x[AW-2:0];
    assign w_uy     = w_cand_y[AW-2:0];

    // Map sizes beyond the coordinate range clamp to it
    assign w_on_map = !w_cand_x[AW-1] && !w_cand_y[AW-1]
                   && ((w_ux >> COORD_BITS) == '0) && ((w_uy >> COORD_BITS) == '0)
                   && (w_ux < (AW-1)'(i_map_width)) && (w_uy < (AW-1)'(i_map_height));

    assign w_dist   = SUM_W'(r_sq_x) + SUM_W'(r_sq_y);
    assign w_scaled = w_dist << (2 * RADIUS_FRAC_BITS);
    assign w_keep   = r_on_map && (w_scaled <= SUM_W'(r_radius_sq));

    assign o_status.xfer     = w_xfer;
    assign o_status.spent    = w_spent;
    assign o_status.miss     = !w_keep;
    assign o_status.out_busy = w_out_busy;

    // Next spiral position
    always_comb begin
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_ring     = r_ring;
        n_edge     = r_edge;
        n_step     = r_step;
        w_step_inc = r_step + RING_BITS'(1);
        if (r_ring <= RING_BITS'(1)) begin
            n_dx   = r_dx - D_BITS'(1);
            n_dy   = r_dy - D_BITS'(1);
            n_ring = RING_BITS'(3);
            n_edge = srpg_pkg::EDGE_TOP;
            n_step = '0;
        end else begin
            unique case (r_edge)
                srpg_pkg::EDGE_TOP:    n_dx = r_dx + D_BITS'(1);
                srpg_pkg::EDGE_RIGHT:  n_dy = r_dy + D_BITS'(1);
                srpg_pkg::EDGE_BOTTOM: n_dx = r_dx - D_BITS'(1);
                srpg_pkg::EDGE_LEFT:   n_dy = r_dy - D_BITS'(1);
            endcase
            if (w_step_inc >= r_ring - RING_BITS'(1)) begin
                n_step = '0;
                n_edge = srpg_pkg::t_edge'(r_edge + 2'd1);
                // ring closed: step out to the next ring's upper-left corner
                if (r_edge == srpg_pkg::EDGE_LEFT) begin
                    n_dx   = n_dx - D_BITS'(1);
                    n_dy   = n_dy - D_BITS'(1);
                    n_ring = r_ring + RING_BITS'(2);
                end
            end else begin
                n_step = w_step_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx        <= '0;
            r_dy        <= '0;
            r_ring      <= RING_BITS'(1);
            r_edge      <= srpg_pkg::EDGE_TOP;
            r_step      <= '0;
            r_visited   <= '0;
            r_budget    <= '0;
            r_radius_sq <= '0;
        end else if (w_start) begin
            r_dx        <= '0;
            r_dy        <= '0;
            r_ring      <= RING_BITS'(1);
            r_edge      <= srpg_pkg::EDGE_TOP;
            r_step      <= '0;
            r_visited   <= '0;
            r_budget    <= w_n * w_n;
            r_radius_sq <= i_radius_q * i_radius_q;
        end else if (w_visit) begin
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_ring    <= n_ring;
            r_edge    <= n_edge;
            r_step    <= n_step;
            r_visited <= r_visited + BUD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_centre_x <= i_start_x;
            r_centre_y <= i_start_y;
        end
        if (w_visit) begin
            r_cand_x <= w_ux[COORD_BITS-1:0];
            r_cand_y <= w_uy[COORD_BITS-1:0];
            r_on_map <= w_on_map;
            r_sq_x   <= r_dx * r_dx;
            r_sq_y   <= r_dy * r_dy;
        end
        // drop the previous verdict on each check; the test step sets it
        if (i_ctrl.visit) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.test) begin
            r_hit <= w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x     <= r_hit ? r_cand_x : '0;
            r_out_y     <= r_hit ? r_cand_y : '0;
            r_out_found <= r_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_point_x  = r_out_x;
    assign o_point_y  = r_out_y;
    assign o_found    = r_out_found;

`ifndef SYNTH
    a_visit_within_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_visited <= r_budget)
        else $error("visit count passed the budget");

    a_ring_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring[0] == 1'b1)
        else $error("ring length is even");

    a_step_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring > RING_BITS'(1)) |-> (r_step < r_ring - RING_BITS'(1)))
        else $error("edge step ran past the edge");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_x == '0 && r_out_y == '0))
        else $error("exhausted result carries a point");
`endif

endmodule

// ----- sv/spiral_radius_point_generator.sv -----
// Square spiral point generator.
// Input stream (s_axis): tuser is the kind (0 start a search, 1 next point);
// tdata carries start_x, start_y and radius_q, read only on a start.
// Output stream (m_axis): one transfer per input transfer; tdata holds
// point_x and point_y, tuser is found (0 once the search is spent).
// APB port: map_width at byte address 0, map_height at 4; write only while idle.
// A microprogram of four steps runs the search. Each spiral position is
// checked, then given a distance test; an item is taken, then positions
// are walked until the next kept point is found, and the result is emitted.
// A search that has run dry goes from the check straight to the emit step.
// The two-step check/test loop repeats until a position is kept or the
// visit budget is spent.
// The result sits in an output register: while the receiver stalls, the
// next item is already taken and searched, and waits only to be emitted.
// Reset clears the search (next items answer found 0 until a start) and sets
// both map sizes to 1024.
module spiral_radius_point_generator #(
    parameter int COORD_BITS       = 10,
    parameter int RADIUS_FRAC_BITS = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, radius_q, zero pad
    input  logic [((2*COORD_BITS+srpg_pkg::RQ_BITS+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  logic s_axis_tuser,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // point_x, point_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // found
    output logic m_axis_tuser,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srpg_pkg::PADDR_BITS-1:0] paddr,
    input  logic [srpg_pkg::APB_DW-1:0]     pwdata,
    output logic [srpg_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

    logic [srpg_pkg::MAP_BITS-1:0] r_map_width;
    logic [srpg_pkg::MAP_BITS-1:0] r_map_height;
    logic [srpg_pkg::MAP_BITS-1:0] w_rd_reg;
    logic                          w_wr;

    srpg_pkg::t_ctrl   w_ctrl;
    srpg_pkg::t_status w_status;

    logic [COORD_BITS-1:0] w_point_x;
    logic [COORD_BITS-1:0] w_point_y;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= srpg_pkg::MAP_RESET;
            r_map_height <= srpg_pkg::MAP_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                srpg_pkg::REG_MAP_WIDTH:  r_map_width  <= pwdata[srpg_pkg::MAP_BITS-1:0];
                srpg_pkg::REG_MAP_HEIGHT: r_map_height <= pwdata[srpg_pkg::MAP_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            srpg_pkg::REG_MAP_WIDTH:  w_rd_reg = r_map_width;
            srpg_pkg::REG_MAP_HEIGHT: w_rd_reg = r_map_height;
        endcase
    end

    assign prdata = srpg_pkg::APB_DW'(w_rd_reg);

    srpg_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    srpg_dp #(
        .COORD_BITS       (COORD_BITS),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_status     (w_status),
        .i_s_tvalid   (s_axis_tvalid),
        .i_kind       (s_axis_tuser),
        .i_start_x    (s_axis_tdata[COORD_BITS-1:0]),
        .i_start_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_radius_q   (s_axis_tdata[2*COORD_BITS+srpg_pkg::RQ_BITS-1:2*COORD_BITS]),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_point_x    (w_point_x),
        .o_point_y    (w_point_y),
        .o_found      (m_axis_tuser)
    );

    assign s_axis_tready = w_ctrl.take_input;
    assign m_axis_tdata  = OUT_W'({w_point_y, w_point_x});

endmodule
